[hdl/assert_macros.svh]
// Assertion macros shared by the yaw alignment search RTL.
// Depends on nothing; files that assert include it by name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define YAS_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("yas assertion failed");

// Next-cycle implication, disabled while reset is low.
`define YAS_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("yas assertion failed");

`endif

[hdl/yas_pkg.sv]
// Types, widths, register indexes and the sine table of the yaw alignment search.
// Depends on nothing.
package yas_pkg;

    localparam int CFG_W   = 24;
    localparam int IDX_W   = 3;
    localparam int STEP_W  = 10;
    localparam int DIM_W   = 13;
    localparam int TRIG_W  = 17;
    localparam int U_W     = 25;
    localparam int MUL_W   = 26;
    localparam int PROD_W  = 52;
    localparam int DEN_W   = 44;
    localparam int DVD_W   = 56;
    localparam int DVS_W   = 42;
    localparam int Q_W     = 57;
    localparam int CRD_W   = 40;
    localparam int XQ_W    = 64;
    localparam int SUM_W   = 32;
    localparam int CNT_W   = 25;
    localparam int ANG_W   = 7;
    localparam int SCORE_W = 16;
    localparam int PIX_W   = 8;

    localparam logic [IDX_W-1:0] REG_FOCAL  = 3'd0;
    localparam logic [IDX_W-1:0] REG_STEP_X = 3'd1;
    localparam logic [IDX_W-1:0] REG_STEP_Y = 3'd2;
    localparam logic [IDX_W-1:0] REG_WIDTH  = 3'd3;
    localparam logic [IDX_W-1:0] REG_HEIGHT = 3'd4;

    typedef struct packed {
        logic                    start;
        logic signed [Q_W-1:0]   dividend;
        logic [DVS_W-1:0]        divisor;
    } t_div_req;

    typedef struct packed {
        logic                    busy;
        logic                    done;
        logic signed [Q_W-1:0]   quot;
    } t_div_rsp;

    // Sine of whole degrees 0..90 in Q1.15.
    function automatic logic [15:0] sine(input logic [6:0] k);
        logic [15:0] v;
        case (k)
            7'd0: v = 16'd0;      7'd1: v = 16'd572;    7'd2: v = 16'd1144;
            7'd3: v = 16'd1715;   7'd4: v = 16'd2286;   7'd5: v = 16'd2856;
            7'd6: v = 16'd3425;   7'd7: v = 16'd3993;   7'd8: v = 16'd4560;
            7'd9: v = 16'd5126;   7'd10: v = 16'd5690;  7'd11: v = 16'd6252;
            7'd12: v = 16'd6813;  7'd13: v = 16'd7371;  7'd14: v = 16'd7927;
            7'd15: v = 16'd8481;  7'd16: v = 16'd9032;  7'd17: v = 16'd9580;
            7'd18: v = 16'd10126; 7'd19: v = 16'd10668; 7'd20: v = 16'd11207;
            7'd21: v = 16'd11743; 7'd22: v = 16'd12275; 7'd23: v = 16'd12803;
            7'd24: v = 16'd13328; 7'd25: v = 16'd13848; 7'd26: v = 16'd14365;
            7'd27: v = 16'd14876; 7'd28: v = 16'd15384; 7'd29: v = 16'd15886;
            7'd30: v = 16'd16384; 7'd31: v = 16'd16877; 7'd32: v = 16'd17364;
            7'd33: v = 16'd17847; 7'd34: v = 16'd18324; 7'd35: v = 16'd18795;
            7'd36: v = 16'd19261; 7'd37: v = 16'd19720; 7'd38: v = 16'd20174;
            7'd39: v = 16'd20622; 7'd40: v = 16'd21063; 7'd41: v = 16'd21498;
            7'd42: v = 16'd21926; 7'd43: v = 16'd22348; 7'd44: v = 16'd22763;
            7'd45: v = 16'd23170; 7'd46: v = 16'd23571; 7'd47: v = 16'd23965;
            7'd48: v = 16'd24351; 7'd49: v = 16'd24730; 7'd50: v = 16'd25102;
            7'd51: v = 16'd25466; 7'd52: v = 16'd25822; 7'd53: v = 16'd26170;
            7'd54: v = 16'd26510; 7'd55: v = 16'd26842; 7'd56: v = 16'd27166;
            7'd57: v = 16'd27482; 7'd58: v = 16'd27789; 7'd59: v = 16'd28088;
            7'd60: v = 16'd28378; 7'd61: v = 16'd28660; 7'd62: v = 16'd28932;
            7'd63: v = 16'd29197; 7'd64: v = 16'd29452; 7'd65: v = 16'd29698;
            7'd66: v = 16'd29935; 7'd67: v = 16'd30163; 7'd68: v = 16'd30382;
            7'd69: v = 16'd30592; 7'd70: v = 16'd30792; 7'd71: v = 16'd30983;
            7'd72: v = 16'd31164; 7'd73: v = 16'd31336; 7'd74: v = 16'd31499;
            7'd75: v = 16'd31651; 7'd76: v = 16'd31795; 7'd77: v = 16'd31928;
            7'd78: v = 16'd32052; 7'd79: v = 16'd32166; 7'd80: v = 16'd32270;
            7'd81: v = 16'd32365; 7'd82: v = 16'd32449; 7'd83: v = 16'd32524;
            7'd84: v = 16'd32588; 7'd85: v = 16'd32643; 7'd86: v = 16'd32688;
            7'd87: v = 16'd32723; 7'd88: v = 16'd32748; 7'd89: v = 16'd32763;
            7'd90: v = 16'd32768;
            default: v = 16'd0;
        endcase
        return v;
    endfunction

endpackage

[hdl/yas_in_if.sv]
// Input channel of the yaw alignment search: one pixel pair per item.
// Depends on yas_pkg.
interface yas_in_if;
    logic                        valid;
    logic                        ready;
    logic [yas_pkg::PIX_W-1:0]   ref_pixel;
    logic [yas_pkg::PIX_W-1:0]   cur_pixel;
    logic                        last_pixel;

    modport source (output valid, ref_pixel, cur_pixel, last_pixel, input ready);
    modport sink   (input valid, ref_pixel, cur_pixel, last_pixel, output ready);
endinterface

[hdl/yas_out_if.sv]
// Output channel of the yaw alignment search: one search result per item.
// Depends on yas_pkg.
interface yas_out_if;
    logic                                valid;
    logic                                ready;
    logic signed [yas_pkg::ANG_W-1:0]    best_angle;
    logic [yas_pkg::SCORE_W-1:0]         best_score;
    logic                                no_overlap;

    modport source (output valid, best_angle, best_score, no_overlap, input ready);
    modport sink   (input valid, best_angle, best_score, no_overlap, output ready);
endinterface

[hdl/yaw_alignment_search.sv]
// Top level of the yaw alignment search: image load, warp sequencer and result register.
// Depends on yas_pkg, yas_in_if, yas_out_if, yas_ram, yas_div and assert_macros.svh.
//
//  channel   dir  handshake      payload
//  i_in      in   valid/ready    ref_pixel, cur_pixel, last_pixel
//  o_out     out  valid/ready    best_angle, best_score, no_overlap
//  i_cfg_*   in   write enable   register index, write data
//
// Pixel pairs are taken one per cycle while idle and written to two pixel memories.
// The item marked last starts the sweep; input stalls until the result is loaded.
// Each grid point that lands inside costs 3 divisions, each row one more division,
// each angle with any sample one more for the mean. All divisions share one
// bit-serial divider. A pending result does not block loading.
// Reset needs no clearing pass; the pixel memories are undefined until written.
`include "assert_macros.svh"

module yaw_alignment_search #(
    parameter int MAX_WIDTH  = 512,
    parameter int MAX_HEIGHT = 512,
    parameter int ANGLE_SPAN = 40
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    yas_in_if.sink                        i_in,
    yas_out_if.source                     o_out,
    input  logic                          i_cfg_we,
    input  logic [yas_pkg::IDX_W-1:0]     i_cfg_idx,
    input  logic [yas_pkg::CFG_W-1:0]     i_cfg_data
);
    localparam int DEPTH  = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW     = $clog2(DEPTH);
    localparam int SPAN   = (ANGLE_SPAN > 89) ? 89 : ANGLE_SPAN;

    localparam int DIM_W  = yas_pkg::DIM_W;
    localparam int STEP_W = yas_pkg::STEP_W;
    localparam int CFG_W  = yas_pkg::CFG_W;
    localparam int TRIG_W = yas_pkg::TRIG_W;
    localparam int U_W    = yas_pkg::U_W;
    localparam int MUL_W  = yas_pkg::MUL_W;
    localparam int PROD_W = yas_pkg::PROD_W;
    localparam int DEN_W  = yas_pkg::DEN_W;
    localparam int DVS_W  = yas_pkg::DVS_W;
    localparam int Q_W    = yas_pkg::Q_W;
    localparam int CRD_W  = yas_pkg::CRD_W;
    localparam int XQ_W   = yas_pkg::XQ_W;
    localparam int SUM_W  = yas_pkg::SUM_W;
    localparam int CNT_W  = yas_pkg::CNT_W;
    localparam int ANG_W  = yas_pkg::ANG_W;
    localparam int SC_W   = yas_pkg::SCORE_W;
    localparam int PIX_W  = yas_pkg::PIX_W;

    localparam logic signed [Q_W-1:0]   SAT_P  = Q_W'(64'sd274877906944);
    localparam logic signed [Q_W-1:0]   SAT_N  = -SAT_P;
    localparam logic signed [7:0]       SPAN8  = 8'(SPAN);

    localparam logic [4:0] S_IDLE  = 5'd0;
    localparam logic [4:0] S_ANG   = 5'd1;
    localparam logic [4:0] S_ROW   = 5'd2;
    localparam logic [4:0] S_VWAIT = 5'd3;
    localparam logic [4:0] S_COL   = 5'd4;
    localparam logic [4:0] S_UWAIT = 5'd5;
    localparam logic [4:0] S_M1    = 5'd6;
    localparam logic [4:0] S_M2    = 5'd7;
    localparam logic [4:0] S_M3    = 5'd8;
    localparam logic [4:0] S_XWAIT = 5'd9;
    localparam logic [4:0] S_YWAIT = 5'd10;
    localparam logic [4:0] S_P1    = 5'd11;
    localparam logic [4:0] S_P2    = 5'd12;
    localparam logic [4:0] S_P3    = 5'd13;
    localparam logic [4:0] S_P4    = 5'd14;
    localparam logic [4:0] S_P5    = 5'd15;
    localparam logic [4:0] S_CHK   = 5'd16;
    localparam logic [4:0] S_A0    = 5'd17;
    localparam logic [4:0] S_A1    = 5'd18;
    localparam logic [4:0] S_A2    = 5'd19;
    localparam logic [4:0] S_A3    = 5'd20;
    localparam logic [4:0] S_A4    = 5'd21;
    localparam logic [4:0] S_B1    = 5'd22;
    localparam logic [4:0] S_B2    = 5'd23;
    localparam logic [4:0] S_B3    = 5'd24;
    localparam logic [4:0] S_NEXT  = 5'd25;
    localparam logic [4:0] S_AEND  = 5'd26;
    localparam logic [4:0] S_MWAIT = 5'd27;
    localparam logic [4:0] S_ANEXT = 5'd28;
    localparam logic [4:0] S_DONE  = 5'd29;

    function automatic logic signed [CRD_W-1:0] sat_coord(input logic signed [Q_W-1:0] q);
        logic signed [Q_W-1:0] t;
        if (q > SAT_P) begin
            t = SAT_P;
        end else if (q < SAT_N) begin
            t = SAT_N;
        end else begin
            t = q;
        end
        return t[CRD_W-1:0];
    endfunction

    logic [4:0]                 r_state;
    logic [CFG_W-1:0]           r_focal;
    logic [STEP_W-1:0]          r_step_x, r_step_y, r_width, r_height;
    logic [CFG_W-1:0]           r_f;
    logic [STEP_W-1:0]          r_sx, r_sy;
    logic [DIM_W-1:0]           r_w, r_h;
    logic [AW-1:0]              r_load_idx;
    logic signed [7:0]          r_ang;
    logic signed [TRIG_W-1:0]   r_sin, r_cos;
    logic [DIM_W:0]             r_y, r_x;
    logic signed [U_W-1:0]      r_v, r_u;
    logic [AW-1:0]              r_gbase;
    logic signed [PROD_W-1:0]   r_prod;
    logic signed [DEN_W-1:0]    r_den;
    logic signed [CRD_W-1:0]    r_xn, r_yn;
    logic signed [XQ_W-1:0]     r_acc, r_xq, r_yq;
    logic [DIM_W-1:0]           r_x0, r_x1;
    logic                       r_ystep;
    logic [7:0]                 r_wx, r_wy;
    logic [PIX_W-1:0]           r_p00, r_p01, r_p10, r_p11, r_cv, r_smp;
    logic signed [19:0]         r_pa, r_pb;
    logic [SUM_W-1:0]           r_sum;
    logic [CNT_W-1:0]           r_cnt;
    logic                       r_found;
    logic [SC_W-1:0]            r_best_mean;
    logic signed [7:0]          r_best_yaw;
    logic                       r_out_valid;
    logic [ANG_W-1:0]           r_out_angle;
    logic [SC_W-1:0]            r_out_score;
    logic                       r_out_nov;

    yas_pkg::t_div_req          div_req;
    yas_pkg::t_div_rsp          div_rsp;

    logic                       in_acc;
    logic                       m_en;
    logic signed [MUL_W-1:0]    m_a, m_b;
    logic signed [PROD_W-1:0]   n_prod;
    logic signed [MUL_W-1:0]    f_s;
    logic signed [15:0]         dx, dy;
    logic signed [PROD_W-1:0]   n_num;
    logic signed [XQ_W-1:0]     w_half, h_half, w_full, h_full, n_coord;
    logic [DIM_W-1:0]           y0, x0;
    logic [DIM_W:0]             x0p1, y0p1;
    logic [6:0]                 mag;
    logic [AW-1:0]              row0, row1;
    logic [AW-1:0]              ref_raddr, cur_raddr;
    logic [PIX_W-1:0]           ref_rdata, cur_rdata;
    logic signed [9:0]          d0, d1;
    logic signed [20:0]         dp;
    logic signed [29:0]         pfull;
    logic [PIX_W-1:0]           adiff;
    logic [SC_W-1:0]            mean;
    logic [DIM_W-1:0]           w_clamp, h_clamp;

    assign in_acc = i_in.valid && i_in.ready;
    assign i_in.ready = (r_state == S_IDLE);

    assign o_out.valid      = r_out_valid;
    assign o_out.best_angle = r_out_angle;
    assign o_out.best_score = r_out_score;
    assign o_out.no_overlap = r_out_nov;

    yas_ram #(.DATA_W(PIX_W), .DEPTH(DEPTH)) u_ref_ram (
        .i_clk   (i_clk),
        .i_we    (in_acc),
        .i_waddr (r_load_idx),
        .i_wdata (i_in.ref_pixel),
        .i_raddr (ref_raddr),
        .o_rdata (ref_rdata)
    );

    yas_ram #(.DATA_W(PIX_W), .DEPTH(DEPTH)) u_cur_ram (
        .i_clk   (i_clk),
        .i_we    (in_acc),
        .i_waddr (r_load_idx),
        .i_wdata (i_in.cur_pixel),
        .i_raddr (cur_raddr),
        .o_rdata (cur_rdata)
    );

    yas_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    assign w_clamp = (DIM_W'(r_width) < DIM_W'(2)) ? DIM_W'(2) :
                     (DIM_W'(r_width) > DIM_W'(MAX_WIDTH)) ? DIM_W'(MAX_WIDTH) : DIM_W'(r_width);
    assign h_clamp = (DIM_W'(r_height) < DIM_W'(2)) ? DIM_W'(2) :
                     (DIM_W'(r_height) > DIM_W'(MAX_HEIGHT)) ? DIM_W'(MAX_HEIGHT) :
                     DIM_W'(r_height);

    assign f_s    = MUL_W'(signed'({1'b0, r_f}));
    assign dx     = signed'({1'b0, r_x, 1'b0}) - signed'({3'b0, r_w});
    assign dy     = signed'({1'b0, r_y, 1'b0}) - signed'({3'b0, r_h});
    assign n_num  = r_prod + (PROD_W'(r_sin) <<< 12);
    assign w_half = signed'(XQ_W'({r_w, 11'd0}));
    assign h_half = signed'(XQ_W'({r_h, 11'd0}));
    assign w_full = signed'(XQ_W'({r_w, 12'd0}));
    assign h_full = signed'(XQ_W'({r_h, 12'd0}));
    assign n_coord = (r_acc + XQ_W'(r_prod)) >>> 8;
    assign x0     = r_xq[12 +: DIM_W];
    assign y0     = r_yq[12 +: DIM_W];
    assign x0p1   = {1'b0, x0} + 1'b1;
    assign y0p1   = {1'b0, y0} + 1'b1;
    assign mag    = r_ang[7] ? 7'(-r_ang) : 7'(r_ang);
    assign row0   = r_prod[AW-1:0];
    assign row1   = r_ystep ? AW'(row0 + AW'(r_w)) : row0;
    assign d0     = signed'({2'b0, r_p01}) - signed'({2'b0, r_p00});
    assign d1     = signed'({2'b0, r_p11}) - signed'({2'b0, r_p10});
    assign dp     = 21'(r_pb) - 21'(r_pa);
    assign pfull  = (30'(r_pa) <<< 8) + 30'(dp) * 30'(signed'({1'b0, r_wx}))
                    + 30'sd32768;
    assign adiff  = (r_smp > r_cv) ? (r_smp - r_cv) : (r_cv - r_smp);
    assign mean   = (div_rsp.quot > Q_W'(65535)) ? SC_W'(65535) : div_rsp.quot[SC_W-1:0];
    assign n_prod = m_a * m_b;

    always_comb begin
        m_en = 1'b0;
        m_a  = '0;
        m_b  = '0;
        case (r_state)
            S_ROW: begin
                m_en = 1'b1;
                m_a  = MUL_W'(signed'({1'b0, r_y}));
                m_b  = MUL_W'(signed'({1'b0, r_w}));
            end
            S_M1: begin
                m_en = 1'b1;
                m_a  = MUL_W'(r_sin);
                m_b  = MUL_W'(r_u);
            end
            S_M2: begin
                m_en = 1'b1;
                m_a  = MUL_W'(r_cos);
                m_b  = MUL_W'(r_u);
            end
            S_P1: begin
                m_en = 1'b1;
                m_a  = MUL_W'(signed'(r_xn[CRD_W-1:20]));
                m_b  = f_s;
            end
            S_P2: begin
                m_en = 1'b1;
                m_a  = MUL_W'(signed'({1'b0, r_xn[19:0]}));
                m_b  = f_s;
            end
            S_P3: begin
                m_en = 1'b1;
                m_a  = MUL_W'(signed'(r_yn[CRD_W-1:20]));
                m_b  = f_s;
            end
            S_P4: begin
                m_en = 1'b1;
                m_a  = MUL_W'(signed'({1'b0, r_yn[19:0]}));
                m_b  = f_s;
            end
            S_CHK: begin
                m_en = 1'b1;
                m_a  = MUL_W'(signed'({1'b0, y0}));
                m_b  = MUL_W'(signed'({1'b0, r_w}));
            end
            default: begin
                m_en = 1'b0;
            end
        endcase
    end

    always_comb begin
        div_req.start    = 1'b0;
        div_req.dividend = '0;
        div_req.divisor  = DVS_W'(r_f);
        case (r_state)
            S_ROW: begin
                div_req.start    = (r_y < {1'b0, r_h});
                div_req.dividend = Q_W'(dy) <<< 19;
            end
            S_COL: begin
                div_req.start    = (r_x < {1'b0, r_w});
                div_req.dividend = Q_W'(dx) <<< 19;
            end
            S_M3: begin
                div_req.start    = !(r_den[DEN_W-1] || (r_den == '0));
                div_req.dividend = Q_W'(n_num) <<< 12;
                div_req.divisor  = DVS_W'(r_den);
            end
            S_XWAIT: begin
                div_req.start    = div_rsp.done;
                div_req.dividend = Q_W'(r_v) <<< 27;
                div_req.divisor  = DVS_W'(r_den);
            end
            S_AEND: begin
                div_req.start    = (r_cnt != '0);
                div_req.dividend = signed'(Q_W'({r_sum, 8'd0}));
                div_req.divisor  = DVS_W'(r_cnt);
            end
            default: begin
                div_req.start = 1'b0;
            end
        endcase
    end

    always_comb begin
        ref_raddr = row0 + AW'(r_x0);
        case (r_state)
            S_A1:    ref_raddr = AW'(row1 + AW'(r_x0));
            S_A2:    ref_raddr = AW'(row0 + AW'(r_x1));
            S_A3:    ref_raddr = AW'(row1 + AW'(r_x1));
            default: ref_raddr = AW'(row0 + AW'(r_x0));
        endcase
    end

    assign cur_raddr = AW'(r_gbase + AW'(r_x));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_focal  <= CFG_W'(98852);
            r_step_x <= STEP_W'(1);
            r_step_y <= STEP_W'(1);
            r_width  <= STEP_W'(512);
            r_height <= STEP_W'(512);
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                yas_pkg::REG_FOCAL:  r_focal  <= i_cfg_data;
                yas_pkg::REG_STEP_X: r_step_x <= i_cfg_data[STEP_W-1:0];
                yas_pkg::REG_STEP_Y: r_step_y <= i_cfg_data[STEP_W-1:0];
                yas_pkg::REG_WIDTH:  r_width  <= i_cfg_data[STEP_W-1:0];
                yas_pkg::REG_HEIGHT: r_height <= i_cfg_data[STEP_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_load_idx  <= '0;
            r_found     <= 1'b0;
            r_best_mean <= '1;
            r_best_yaw  <= '0;
            r_out_valid <= 1'b0;
            r_sum       <= '0;
            r_cnt       <= '0;
        end else begin
            if (r_out_valid && o_out.ready && (r_state != S_DONE)) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        if (i_in.last_pixel) begin
                            r_load_idx  <= '0;
                            r_f         <= (r_focal < CFG_W'(256)) ? CFG_W'(256) : r_focal;
                            r_sx        <= (r_step_x == '0) ? STEP_W'(1) : r_step_x;
                            r_sy        <= (r_step_y == '0) ? STEP_W'(1) : r_step_y;
                            r_w         <= w_clamp;
                            r_h         <= h_clamp;
                            r_ang       <= -SPAN8;
                            r_found     <= 1'b0;
                            r_best_mean <= '1;
                            r_best_yaw  <= '0;
                            r_state     <= S_ANG;
                        end else begin
                            r_load_idx <= (r_load_idx == AW'(DEPTH - 1)) ? '0
                                                                          : r_load_idx + 1'b1;
                        end
                    end
                end
                S_ANG: begin
                    r_sin   <= r_ang[7] ? -TRIG_W'(yas_pkg::sine(mag))
                                        : TRIG_W'(yas_pkg::sine(mag));
                    r_cos   <= TRIG_W'(yas_pkg::sine(7'(7'd90 - mag)));
                    r_sum   <= '0;
                    r_cnt   <= '0;
                    r_y     <= '0;
                    r_state <= S_ROW;
                end
                S_ROW: begin
                    r_state <= (r_y < {1'b0, r_h}) ? S_VWAIT : S_AEND;
                end
                S_VWAIT: begin
                    if (div_rsp.done) begin
                        r_v     <= div_rsp.quot[U_W-1:0];
                        r_gbase <= r_prod[AW-1:0];
                        r_x     <= '0;
                        r_state <= S_COL;
                    end
                end
                S_COL: begin
                    if (r_x < {1'b0, r_w}) begin
                        r_state <= S_UWAIT;
                    end else begin
                        r_y     <= r_y + (DIM_W + 1)'(r_sy);
                        r_state <= S_ROW;
                    end
                end
                S_UWAIT: begin
                    if (div_rsp.done) begin
                        r_u     <= div_rsp.quot[U_W-1:0];
                        r_state <= S_M1;
                    end
                end
                S_M1: r_state <= S_M2;
                S_M2: begin
                    r_den   <= DEN_W'((PROD_W'(r_cos) <<< 12) - r_prod);
                    r_state <= S_M3;
                end
                S_M3: begin
                    r_state <= (r_den[DEN_W-1] || (r_den == '0)) ? S_NEXT : S_XWAIT;
                end
                S_XWAIT: begin
                    if (div_rsp.done) begin
                        r_xn    <= sat_coord(div_rsp.quot);
                        r_state <= S_YWAIT;
                    end
                end
                S_YWAIT: begin
                    if (div_rsp.done) begin
                        r_yn    <= sat_coord(div_rsp.quot);
                        r_state <= S_P1;
                    end
                end
                S_P1: r_state <= S_P2;
                S_P2: begin
                    r_acc   <= XQ_W'(r_prod) <<< 20;
                    r_state <= S_P3;
                end
                S_P3: begin
                    r_xq    <= n_coord + w_half;
                    r_state <= S_P4;
                end
                S_P4: begin
                    r_acc   <= XQ_W'(r_prod) <<< 20;
                    r_state <= S_P5;
                end
                S_P5: begin
                    r_yq    <= n_coord + h_half;
                    r_state <= S_CHK;
                end
                S_CHK: begin
                    r_x0    <= x0;
                    r_x1    <= (x0p1 < {1'b0, r_w}) ? x0p1[DIM_W-1:0] : DIM_W'(r_w - 1'b1);
                    r_ystep <= (y0p1 < {1'b0, r_h});
                    r_wx    <= r_xq[11:4];
                    r_wy    <= r_yq[11:4];
                    if (r_xq[XQ_W-1] || (r_xq >= w_full) || r_yq[XQ_W-1] || (r_yq >= h_full)) begin
                        r_state <= S_NEXT;
                    end else begin
                        r_state <= S_A0;
                    end
                end
                S_A0: r_state <= S_A1;
                S_A1: begin
                    r_p00   <= ref_rdata;
                    r_cv    <= cur_rdata;
                    r_state <= S_A2;
                end
                S_A2: begin
                    r_p01   <= ref_rdata;
                    r_state <= S_A3;
                end
                S_A3: begin
                    r_p10   <= ref_rdata;
                    r_state <= S_A4;
                end
                S_A4: begin
                    r_p11   <= ref_rdata;
                    r_state <= S_B1;
                end
                S_B1: begin
                    r_pa    <= 20'(signed'({2'b0, r_p00, 8'd0}))
                               + 20'(d0) * 20'(signed'({1'b0, r_wy}));
                    r_pb    <= 20'(signed'({2'b0, r_p10, 8'd0}))
                               + 20'(d1) * 20'(signed'({1'b0, r_wy}));
                    r_state <= S_B2;
                end
                S_B2: begin
                    r_smp   <= pfull[23:16];
                    r_state <= S_B3;
                end
                S_B3: begin
                    r_sum   <= r_sum + SUM_W'(adiff);
                    r_cnt   <= r_cnt + 1'b1;
                    r_state <= S_NEXT;
                end
                S_NEXT: begin
                    r_x     <= r_x + (DIM_W + 1)'(r_sx);
                    r_state <= S_COL;
                end
                S_AEND: begin
                    r_state <= (r_cnt == '0) ? S_ANEXT : S_MWAIT;
                end
                S_MWAIT: begin
                    if (div_rsp.done) begin
                        if (!r_found || (mean < r_best_mean)) begin
                            r_best_mean <= mean;
                            r_best_yaw  <= r_ang;
                            r_found     <= 1'b1;
                        end
                        r_state <= S_ANEXT;
                    end
                end
                S_ANEXT: begin
                    if (r_ang == SPAN8) begin
                        r_state <= S_DONE;
                    end else begin
                        r_ang   <= r_ang + 8'sd1;
                        r_state <= S_ANG;
                    end
                end
                S_DONE: begin
                    if (!r_out_valid || o_out.ready) begin
                        r_out_valid <= 1'b1;
                        r_out_angle <= r_best_yaw[ANG_W-1:0];
                        r_out_score <= r_best_mean;
                        r_out_nov   <= !r_found;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (m_en) begin
            r_prod <= n_prod;
        end
    end

    `YAS_ASSERT_IMP(a_div_start_idle, i_clk, i_rst_n, div_req.start, !div_rsp.busy)
    `YAS_ASSERT_IMP(a_no_overlap_score, i_clk, i_rst_n, r_out_valid && r_out_nov, (r_out_score == '1) && (r_out_angle == '0))
    `YAS_ASSERT_IMP(a_out_from_done, i_clk, i_rst_n, $rose(r_out_valid), $past(r_state) == S_DONE)
    `YAS_ASSERT_IMP(a_empty_sum, i_clk, i_rst_n, (r_cnt == '0) && (r_state != S_IDLE), r_sum == '0)
endmodule

[hdl/yas_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
// Depends on nothing.
module yas_ram #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = 1024
) (
    input  logic                       i_clk,
    input  logic                       i_we,
    input  logic [$clog2(DEPTH)-1:0]   i_waddr,
    input  logic [DATA_W-1:0]          i_wdata,
    input  logic [$clog2(DEPTH)-1:0]   i_raddr,
    output logic [DATA_W-1:0]          o_rdata
);
    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

[hdl/yas_div.sv]
// Radix-2 restoring divider, one quotient bit per cycle, quotient rounded to minus infinity.
// Depends on yas_pkg; the divisor must be positive, which the divider itself does not check.
module yas_div (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  yas_pkg::t_div_req   i_req,
    output yas_pkg::t_div_rsp   o_rsp
);
    localparam int DVD_W = yas_pkg::DVD_W;
    localparam int DVS_W = yas_pkg::DVS_W;
    localparam int Q_W   = yas_pkg::Q_W;
    localparam int CW    = $clog2(DVD_W);

    logic                r_busy;
    logic                r_done;
    logic [CW-1:0]       r_cnt;
    logic [DVS_W-1:0]    r_rem;
    logic [DVD_W-1:0]    r_quo;
    logic [DVS_W-1:0]    r_dvs;
    logic                r_neg;

    logic [Q_W-1:0]      mag;
    logic [DVS_W:0]      trial;
    logic [DVS_W:0]      diff;
    logic                ge;
    logic [DVS_W-1:0]    n_rem;
    logic [Q_W-1:0]      qz;

    assign mag   = i_req.dividend[Q_W-1] ? Q_W'(-i_req.dividend) : Q_W'(i_req.dividend);
    assign trial = {r_rem, r_quo[DVD_W-1]};
    assign diff  = trial - {1'b0, r_dvs};
    assign ge    = trial >= {1'b0, r_dvs};
    assign n_rem = ge ? diff[DVS_W-1:0] : trial[DVS_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CW'(DVD_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_quo <= mag[DVD_W-1:0];
            r_rem <= '0;
            r_neg <= i_req.dividend[Q_W-1];
            r_dvs <= i_req.divisor;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_quo <= {r_quo[DVD_W-2:0], ge};
        end
    end

    assign qz = {1'b0, r_quo};

    always_comb begin
        o_rsp.busy = r_busy;
        o_rsp.done = r_done;
        if (r_neg) begin
            o_rsp.quot = (r_rem != '0) ? signed'(~qz) : signed'(-qz);
        end else begin
            o_rsp.quot = signed'(qz);
        end
    end
endmodule
